[rtl/tklr_pkg.sv]
// Package for the triangle-kernel line resampler.
// Field widths, register indexes, request kinds and controller states.
// No dependencies.
package tklr_pkg;

  localparam int PIX_W      = 14;  // pixel_index / out_position
  localparam int CH_W       = 8;   // one colour channel
  localparam int RGB_W      = 3 * CH_W;
  localparam int DATA_W     = 40;  // 38 payload bits padded to whole bytes
  localparam int STEP_W     = 21;
  localparam int TAPS_W     = 6;
  localparam int NORM_W     = 17;
  localparam int LEN_W      = 11;
  localparam int CFG_W      = 21;  // widest register
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_BITS  = 16;
  localparam int CENTRE_W   = PIX_W + STEP_W - FRAC_BITS;
  localparam int ROUND_HALF = 32768;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(3);
  localparam logic [NORM_W-1:0] NORM_RESET = NORM_W'(16384);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP        = 2'd0,
    REG_TAP_COUNT   = 2'd1,
    REG_NORM_RECIP  = 2'd2,
    REG_LINE_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_COMPUTE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CENTRE,
    S_TAPS,
    S_DRAIN,
    S_SCALE,
    S_OUT
  } state_t;

endpackage

[rtl/triangle_kernel_line_resampler.sv]
// Triangle-kernel RGB line resampler: line store, tap sequencer, scaling.
// Depends on tklr_pkg.
//
// Channel  | Dir | Handshake          | Contents
// ---------+-----+--------------------+-------------------------------------------
// s_*      | in  | s_tvalid/s_tready  | load or compute request (mode in tuser)
// m_*      | out | m_tvalid/m_tready  | one resampled pixel per compute request
// cfg_*    | in  | cfg_we             | register write, no read-back
//
// A load request writes its pixel to the line store if pixel_index lies in
// the line. A compute request steps through product, centre, tap (one
// line-store read per tap on the single read port), drain, scale and output
// states. Reset (rst, synchronous) clears control state and registers; the
// line store is not cleared. A full output register stalls the request in
// its last state; new requests are taken as soon as that result is parked.
module triangle_kernel_line_resampler
  import tklr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_TAPS  = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [13:0] pixel_index, [21:14] red, [29:22] green, [37:30] blue, [39:38] zero
  input  logic [DATA_W-1:0]    s_tdata,
  // [0] mode
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [13:0] out_position, [21:14] out_red, [29:22] out_green, [37:30] out_blue
  output logic [DATA_W-1:0]    m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LENW  = ($clog2(MAX_WIDTH + 1) > PIX_W) ? $clog2(MAX_WIDTH + 1) : PIX_W;
  localparam int PW    = LENW + 2;                    // signed tap position
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int TCW   = (TW > TAPS_W) ? TW : TAPS_W;
  localparam int HALFM = MAX_TAPS / 2;
  localparam int ACCW  = $clog2((HALFM + 1) * (HALFM + 1) * 255 + 1);
  localparam int SW    = ACCW + NORM_W + 1;           // scaled sum plus rounding

  // configuration registers
  logic [STEP_W-1:0] step;
  logic [TAPS_W-1:0] tap_count;
  logic [NORM_W-1:0] norm_recip;
  logic [LEN_W-1:0]  line_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_RESET;
      tap_count   <= TAPS_RESET;
      norm_recip  <= NORM_RESET;
      line_length <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP:        step        <= cfg_data[STEP_W-1:0];
        REG_TAP_COUNT:   tap_count   <= cfg_data[TAPS_W-1:0];
        REG_NORM_RECIP:  norm_recip  <= cfg_data[NORM_W-1:0];
        REG_LINE_LENGTH: line_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective line length and tap count
  logic [LENW-1:0] len_raw, len_eff;
  logic [TCW-1:0]  tc_ext;
  logic [TW-1:0]   taps_eff, half_eff;

  always_comb begin
    len_raw = LENW'(line_length);
    if (len_raw == '0)                    len_eff = LENW'(1);
    else if (len_raw > LENW'(MAX_WIDTH))  len_eff = LENW'(MAX_WIDTH);
    else                                  len_eff = len_raw;
    tc_ext = TCW'(tap_count);
    if (tc_ext == '0)                     taps_eff = TW'(1);
    else if (tc_ext > TCW'(MAX_TAPS))     taps_eff = TW'(MAX_TAPS);
    else                                  taps_eff = tc_ext[TW-1:0];
    half_eff = taps_eff >> 1;
  end

  // input fields
  logic [PIX_W-1:0] in_pos;
  logic [RGB_W-1:0] in_rgb;
  logic             in_fire;

  assign in_pos  = s_tdata[PIX_W-1:0];
  assign in_rgb  = {s_tdata[PIX_W +: CH_W], s_tdata[PIX_W+CH_W +: CH_W],
                    s_tdata[PIX_W+2*CH_W +: CH_W]};   // r, g, b
  assign in_fire = s_tvalid && s_tready;

  // controller
  state_t state, state_next;

  logic [PIX_W-1:0]          pos;
  logic [PIX_W+STEP_W-1:0]   prod;
  logic [AW-1:0]             centre;
  logic [TW-1:0]             taps, half, tap_i, weight, w_d;
  logic signed [PW-1:0]      tp;
  logic                      rd_valid;
  logic [ACCW-1:0]           acc_r, acc_g, acc_b;
  logic [ACCW+NORM_W-1:0]    sc_r, sc_g, sc_b;
  logic                      out_free, last_tap;

  assign out_free = !m_tvalid || m_tready;
  assign last_tap = (tap_i == taps - TW'(1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_fire && s_tuser == MODE_COMPUTE) state_next = S_MUL;
      S_MUL:    state_next = S_CENTRE;
      S_CENTRE: state_next = S_TAPS;
      S_TAPS:   if (last_tap) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_SCALE;
      S_SCALE:  state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  logic rd_en, wr_en, load_out;

  always_comb begin
    s_tready = (state == S_IDLE);
    rd_en    = (state == S_TAPS);
    load_out = (state == S_OUT) && out_free;
    wr_en    = in_fire && (s_tuser == MODE_LOAD) && (LENW'(in_pos) < len_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // centre: floor(c*step), saturated to the last pixel
  logic [CENTRE_W-1:0]  centre_raw;
  logic [AW-1:0]        centre_sat;
  logic [LENW-1:0]      len_m1;

  always_comb begin
    centre_raw = prod[PIX_W+STEP_W-1:FRAC_BITS];
    len_m1     = len_eff - LENW'(1);
    if (centre_raw >= CENTRE_W'(len_eff)) centre_sat = len_m1[AW-1:0];
    else                                  centre_sat = centre_raw[AW-1:0];
  end

  // tap address: outside the line falls back on the centre pixel
  logic          tp_inside;
  logic [AW-1:0] rd_addr;

  always_comb begin
    tp_inside = !tp[PW-1] && ($unsigned(tp) < PW'(len_eff));
    rd_addr   = tp_inside ? tp[AW-1:0] : centre;
  end

  always_ff @(posedge clk) begin
    if (in_fire) pos <= in_pos;
    if (state == S_MUL) begin
      prod <= (PIX_W+STEP_W)'(pos) * (PIX_W+STEP_W)'(step);
      taps <= taps_eff;
      half <= half_eff;
    end
    if (state == S_CENTRE) begin
      centre <= centre_sat;
      tp     <= $signed(PW'(centre_sat)) - $signed(PW'(half));
      tap_i  <= '0;
      weight <= TW'(1);
    end
    if (state == S_TAPS) begin
      tap_i  <= tap_i + TW'(1);
      tp     <= tp + PW'(1);
      weight <= (tap_i < half) ? weight + TW'(1) : weight - TW'(1);
      w_d    <= weight;
    end
    if (state == S_SCALE) begin
      sc_r <= (ACCW+NORM_W)'(acc_r) * (ACCW+NORM_W)'(norm_recip);
      sc_g <= (ACCW+NORM_W)'(acc_g) * (ACCW+NORM_W)'(norm_recip);
      sc_b <= (ACCW+NORM_W)'(acc_b) * (ACCW+NORM_W)'(norm_recip);
    end
  end

  // line store: one write port, one registered read port
  logic [RGB_W-1:0] line_store [MAX_WIDTH];
  logic [RGB_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) line_store[in_pos[AW-1:0]] <= in_rgb;
    if (rd_en) rd_data <= line_store[rd_addr];
  end

  // weighted sums; read data arrives in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= rd_en;
  end

  always_ff @(posedge clk) begin
    if (state == S_CENTRE) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (rd_valid) begin
      acc_r <= acc_r + ACCW'(w_d) * ACCW'(rd_data[2*CH_W +: CH_W]);
      acc_g <= acc_g + ACCW'(w_d) * ACCW'(rd_data[CH_W +: CH_W]);
      acc_b <= acc_b + ACCW'(w_d) * ACCW'(rd_data[0 +: CH_W]);
    end
  end

  // round half up, clamp to 255
  function automatic logic [CH_W-1:0] round_clamp(input logic [ACCW+NORM_W-1:0] sc);
    logic [SW-1:0] sum;
    logic [SW-FRAC_BITS-1:0] v;
    sum = SW'(sc) + SW'(ROUND_HALF);
    v   = sum[SW-1:FRAC_BITS];
    return (|v[SW-FRAC_BITS-1:CH_W]) ? {CH_W{1'b1}} : v[CH_W-1:0];
  endfunction

  // output register
  logic [PIX_W-1:0] out_position;
  logic [CH_W-1:0]  out_red, out_green, out_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_position <= pos;
      out_red      <= round_clamp(sc_r);
      out_green    <= round_clamp(sc_g);
      out_blue     <= round_clamp(sc_b);
    end
  end

  assign m_tdata = {(DATA_W-PIX_W-RGB_W)'(0), out_blue, out_green, out_red, out_position};

endmodule

[rtl/tklr_checker.sv]
// Port-level checks for the triangle-kernel line resampler, bound to the top.
// Depends on tklr_pkg and triangle_kernel_line_resampler.
module tklr_checker
  import tklr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  // a load request never yields a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == MODE_LOAD && !m_tvalid |=> !m_tvalid)
    else $error("load request produced a result");

  // a compute request occupies the block
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == MODE_COMPUTE |=> !s_tready ##1 !s_tready)
    else $error("request taken while a compute request is in progress");

endmodule

bind triangle_kernel_line_resampler tklr_checker u_tklr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
